// File: rtl/spq_pkg.sv
// shared types and codes for the sorted priority queue
package spq_pkg;

  localparam int FIELD_W = 16;
  localparam int FILL_W  = 5;
  localparam int CMD_W   = 3;
  localparam int STS_W   = 2;

  localparam logic [CMD_W-1:0] CMD_INSERT  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_EXTRACT = 3'd1;
  localparam logic [CMD_W-1:0] CMD_REMOVE  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_CHANGE  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CLEAR   = 3'd4;

  localparam logic [STS_W-1:0] STS_DONE = 2'd0;
  localparam logic [STS_W-1:0] STS_MISS = 2'd1;
  localparam logic [STS_W-1:0] STS_FULL = 2'd2;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INS,
    OP_DROP,
    OP_CLR
  } cell_op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DROP,
    ST_REINS
  } spq_state_t;

  typedef struct packed {
    cell_op_t             op;
    logic [FIELD_W-1:0]   seq;
    logic [FIELD_W-1:0]   prio;
  } cell_ctl_t;

  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [FIELD_W-1:0] tag;
    logic [FIELD_W-1:0] seq_num;
    logic [FIELD_W-1:0] prio;
  } spq_in_t;

  typedef struct packed {
    logic               head_valid;
    logic [FIELD_W-1:0] head_tag;
    logic [FIELD_W-1:0] head_seq;
    logic [FIELD_W-1:0] head_prio;
    logic [FILL_W-1:0]  fill_count;
    logic [STS_W-1:0]   status;
  } spq_out_t;

endpackage

// File: rtl/spq_cell.sv
// one slot of the sorted row: holds an entry and trades it with its neighbors
module spq_cell import spq_pkg::*; #(
  parameter int TW = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  cell_ctl_t          ctl,
  input  logic [TW-1:0]      new_tag,
  input  logic               shift_en,
  input  logic               left_valid,
  input  logic               left_stay,
  input  logic [TW-1:0]      left_tag,
  input  logic [FIELD_W-1:0] left_seq,
  input  logic [FIELD_W-1:0] left_prio,
  input  logic               right_valid,
  input  logic [TW-1:0]      right_tag,
  input  logic [FIELD_W-1:0] right_seq,
  input  logic [FIELD_W-1:0] right_prio,
  output logic               valid,
  output logic [TW-1:0]      tag,
  output logic [FIELD_W-1:0] seq,
  output logic [FIELD_W-1:0] prio,
  output logic               stay,
  output logic               hit
);

  logic               valid_r, valid_nxt;
  logic [TW-1:0]      tag_r, tag_nxt;
  logic [FIELD_W-1:0] seq_r, seq_nxt;
  logic [FIELD_W-1:0] prio_r, prio_nxt;

  // entries at or below the new priority keep their place
  assign stay  = valid_r && (prio_r <= ctl.prio);
  assign hit   = valid_r && (tag_r == new_tag);
  assign valid = valid_r;
  assign tag   = tag_r;
  assign seq   = seq_r;
  assign prio  = prio_r;

  always_comb begin
    valid_nxt = valid_r;
    tag_nxt   = tag_r;
    seq_nxt   = seq_r;
    prio_nxt  = prio_r;
    unique case (ctl.op)
      OP_INS: begin
        if (!stay) begin
          if (left_stay) begin
            valid_nxt = 1'b1;
            tag_nxt   = new_tag;
            seq_nxt   = ctl.seq;
            prio_nxt  = ctl.prio;
          end else begin
            valid_nxt = left_valid;
            tag_nxt   = left_tag;
            seq_nxt   = left_seq;
            prio_nxt  = left_prio;
          end
        end
      end
      OP_DROP: begin
        if (shift_en) begin
          valid_nxt = right_valid;
          tag_nxt   = right_tag;
          seq_nxt   = right_seq;
          prio_nxt  = right_prio;
        end
      end
      OP_CLR: begin
        valid_nxt = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tag_r  <= tag_nxt;
    seq_r  <= seq_nxt;
    prio_r <= prio_nxt;
  end

endmodule

// File: rtl/sorted_priority_queue_unit.sv
// Sorted priority queue built as a row of DEPTH slot cells, head in cell 0. Every
// command is broadcast to all cells at once; each cell compares its own entry and
// moves by one slot with its neighbor, so the time per beat does not grow with DEPTH.
// Insert, extract, clear and unused codes finish in the execute state; remove by tag
// registers the tag match vector in the execute state and closes the gap in the drop
// state; change priority goes on to the reinsert state (match, remove, reinsert),
// unless the tag is absent. The result sits in an output register, so a new beat is
// taken while the previous result waits. No clearing pass after reset.
module sorted_priority_queue_unit import spq_pkg::*; #(
  parameter int DEPTH    = 16,
  parameter int TAG_BITS = 16
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  spq_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output spq_out_t out_data
);

  localparam int TW   = (TAG_BITS < FIELD_W) ? TAG_BITS : FIELD_W;
  localparam int CW0  = $clog2(DEPTH + 1);
  localparam int CW   = (CW0 < FILL_W) ? FILL_W : CW0;

  spq_state_t          state_r, state_nxt;
  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic                pend_r, pend_nxt;
  logic [STS_W-1:0]    sts_r, sts_nxt;
  logic [CMD_W-1:0]    cmd_r;
  logic [TW-1:0]       tag_r;
  logic [FIELD_W-1:0]  seq_r, seq_nxt;
  logic [FIELD_W-1:0]  prio_r;
  logic [DEPTH-1:0]    hit_r;
  logic                out_valid_r, out_valid_nxt;
  spq_out_t            out_data_r;

  cell_op_t            op;
  logic                fin;
  logic                drop_all;
  logic                accept;
  logic                out_load;
  cell_ctl_t           ctl;

  logic [DEPTH-1:0]    valid_w, stay_w, hit_w, first_w, shift_w;
  logic [TW-1:0]       tag_w  [DEPTH];
  logic [FIELD_W-1:0]  seq_w  [DEPTH];
  logic [FIELD_W-1:0]  prio_w [DEPTH];
  logic [FIELD_W-1:0]  kept_seq;

  assign out_load = pend_r && (!out_valid_r || !out_stall);
  assign in_stall = !((state_r == ST_IDLE) && (!pend_r || out_load));
  assign accept   = in_valid && !in_stall;

  // first matching slot, and every slot from there on closes the gap
  assign first_w = hit_r & (~hit_r + DEPTH'(1));
  assign shift_w = drop_all ? {DEPTH{1'b1}} : ~(first_w - DEPTH'(1));

  always_comb begin
    kept_seq = '0;
    for (int i = 0; i < DEPTH; i++) begin
      kept_seq = kept_seq | ({FIELD_W{first_w[i]}} & seq_w[i]);
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    sts_nxt   = sts_r;
    seq_nxt   = seq_r;
    op        = OP_HOLD;
    fin       = 1'b0;
    drop_all  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_EXEC;
          seq_nxt   = in_data.seq_num;
        end
      end
      ST_EXEC: begin
        state_nxt = ST_IDLE;
        fin       = 1'b1;
        sts_nxt   = STS_DONE;
        unique case (cmd_r) inside
          CMD_INSERT: begin
            if (cnt_r == CW'(DEPTH)) begin
              sts_nxt = STS_FULL;
            end else begin
              op      = OP_INS;
              cnt_nxt = cnt_r + CW'(1);
            end
          end
          CMD_EXTRACT: begin
            if (cnt_r == '0) begin
              sts_nxt = STS_MISS;
            end else begin
              op       = OP_DROP;
              drop_all = 1'b1;
              cnt_nxt  = cnt_r - CW'(1);
            end
          end
          CMD_REMOVE, CMD_CHANGE: begin
            fin       = 1'b0;
            state_nxt = ST_DROP;
          end
          CMD_CLEAR: begin
            op      = OP_CLR;
            cnt_nxt = '0;
          end
          default: begin
          end
        endcase
      end
      ST_DROP: begin
        state_nxt = ST_IDLE;
        fin       = 1'b1;
        if (hit_r == '0) begin
          sts_nxt = STS_MISS;
        end else begin
          op      = OP_DROP;
          cnt_nxt = cnt_r - CW'(1);
          seq_nxt = kept_seq;
          if (cmd_r == CMD_CHANGE) begin
            fin       = 1'b0;
            state_nxt = ST_REINS;
          end
        end
      end
      ST_REINS: begin
        state_nxt = ST_IDLE;
        fin       = 1'b1;
        op        = OP_INS;
        cnt_nxt   = cnt_r + CW'(1);
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign pend_nxt      = fin || (pend_r && !out_load);
  assign out_valid_nxt = out_load || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sts_r <= sts_nxt;
    seq_r <= seq_nxt;
    if (accept) begin
      cmd_r  <= in_data.cmd;
      tag_r  <= in_data.tag[TW-1:0];
      prio_r <= in_data.prio;
    end
    if (state_r == ST_EXEC) begin
      hit_r <= hit_w;
    end
    if (out_load) begin
      out_data_r.head_valid <= (cnt_r != '0);
      out_data_r.head_tag   <= (cnt_r != '0) ? FIELD_W'(tag_w[0]) : '0;
      out_data_r.head_seq   <= (cnt_r != '0) ? seq_w[0] : '0;
      out_data_r.head_prio  <= (cnt_r != '0) ? prio_w[0] : '0;
      out_data_r.fill_count <= cnt_r[FILL_W-1:0];
      out_data_r.status     <= sts_r;
    end
  end

  assign ctl.op   = op;
  assign ctl.seq  = seq_r;
  assign ctl.prio = prio_r;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic               lv, ls, rv;
    logic [TW-1:0]      lt, rt;
    logic [FIELD_W-1:0] lsq, lp, rsq, rp;

    if (i == 0) begin : g_first
      assign lv  = 1'b0;
      assign ls  = 1'b1;
      assign lt  = tag_r;
      assign lsq = seq_r;
      assign lp  = prio_r;
    end else begin : g_mid
      assign lv  = valid_w[i-1];
      assign ls  = stay_w[i-1];
      assign lt  = tag_w[i-1];
      assign lsq = seq_w[i-1];
      assign lp  = prio_w[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign rv  = 1'b0;
      assign rt  = tag_r;
      assign rsq = seq_r;
      assign rp  = prio_r;
    end else begin : g_inner
      assign rv  = valid_w[i+1];
      assign rt  = tag_w[i+1];
      assign rsq = seq_w[i+1];
      assign rp  = prio_w[i+1];
    end

    spq_cell #(
      .TW (TW)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctl         (ctl),
      .new_tag     (tag_r),
      .shift_en    (shift_w[i]),
      .left_valid  (lv),
      .left_stay   (ls),
      .left_tag    (lt),
      .left_seq    (lsq),
      .left_prio   (lp),
      .right_valid (rv),
      .right_tag   (rt),
      .right_seq   (rsq),
      .right_prio  (rp),
      .valid       (valid_w[i]),
      .tag         (tag_w[i]),
      .seq         (seq_w[i]),
      .prio        (prio_w[i]),
      .stay        (stay_w[i]),
      .hit         (hit_w[i])
    );
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: rtl/spq_checker.sv
// port-level checks for the sorted priority queue, bound to the top level
module spq_checker import spq_pkg::*; #(
  parameter int DEPTH = 16
) (
  input logic     clk,
  input logic     rst_n,
  input logic     out_valid,
  input logic     out_stall,
  input spq_out_t out_data
);

  localparam bit FITS = (DEPTH < 32);

  // an empty queue reports a zeroed head
  a_empty_head: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.head_valid) |->
      (out_data.head_tag == '0 && out_data.head_seq == '0 && out_data.head_prio == '0))
    else $error("empty queue reports a nonzero head");

  a_head_vs_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && FITS) |-> (out_data.head_valid == (out_data.fill_count != '0)))
    else $error("head valid disagrees with fill count");

  // a rejected insert only happens on a full queue
  a_full_reject: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && FITS && out_data.status == STS_FULL) |->
      (out_data.fill_count == FILL_W'(DEPTH)))
    else $error("insert rejected while queue not full");

  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && FITS) |-> (out_data.fill_count <= FILL_W'(DEPTH)))
    else $error("fill count beyond depth");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled result beat changed");

endmodule

bind sorted_priority_queue_unit spq_checker #(.DEPTH(DEPTH)) u_spq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// File: tb/sv/tb_top.sv
// self-checking testbench for the sorted priority queue unit
module tb_top;
  import spq_pkg::*;

  localparam int QDEPTH = 16;
  localparam logic [CMD_W-1:0] CMD_UNUSED_LO = 3'd5;
  localparam logic [CMD_W-1:0] CMD_UNUSED_HI = 3'd7;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  spq_in_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  spq_out_t out_data;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_left = 0;
  int err_count = 0;

  logic [FIELD_W-1:0] tag_pool [8];

  // mirror of the queue contents, head at index 0
  logic [FIELD_W-1:0] model_tag  [QDEPTH];
  logic [FIELD_W-1:0] model_seq  [QDEPTH];
  logic [FIELD_W-1:0] model_prio [QDEPTH];
  int model_count = 0;

  spq_out_t expected_heads [$];

  sorted_priority_queue_unit #(
    .DEPTH(QDEPTH),
    .TAG_BITS(FIELD_W)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #2000000;
    $display("tb_top NOT OK");
    $finish;
  end

  // ---------------------------------------------------------------- queue model

  function automatic bit model_put(logic [FIELD_W-1:0] t, logic [FIELD_W-1:0] s,
                                   logic [FIELD_W-1:0] p);
    int pos;
    int i;
    if (model_count >= QDEPTH) return 1'b0;
    pos = 0;
    // ties land behind every entry of equal priority
    while (pos < model_count && model_prio[pos] <= p) pos++;
    for (i = model_count; i > pos; i--) begin
      model_tag[i]  = model_tag[i-1];
      model_seq[i]  = model_seq[i-1];
      model_prio[i] = model_prio[i-1];
    end
    model_tag[pos]  = t;
    model_seq[pos]  = s;
    model_prio[pos] = p;
    model_count++;
    return 1'b1;
  endfunction

  function automatic void model_drop(int pos);
    int i;
    if (pos >= model_count) return;
    for (i = pos; i + 1 < model_count; i++) begin
      model_tag[i]  = model_tag[i+1];
      model_seq[i]  = model_seq[i+1];
      model_prio[i] = model_prio[i+1];
    end
    model_count--;
  endfunction

  function automatic int model_find(logic [FIELD_W-1:0] t);
    int i;
    for (i = 0; i < model_count; i++)
      if (model_tag[i] == t) return i;
    return QDEPTH;
  endfunction

  function automatic spq_out_t predict_head(spq_in_t beat);
    spq_out_t r;
    int pos;
    logic [FIELD_W-1:0] kept_seq;
    logic [STS_W-1:0] sts;
    sts = STS_DONE;
    case (beat.cmd)
      CMD_INSERT: begin
        if (!model_put(beat.tag, beat.seq_num, beat.prio)) sts = STS_FULL;
      end
      CMD_EXTRACT: begin
        if (model_count == 0) sts = STS_MISS;
        else model_drop(0);
      end
      CMD_REMOVE: begin
        pos = model_find(beat.tag);
        if (pos >= QDEPTH) sts = STS_MISS;
        else model_drop(pos);
      end
      CMD_CHANGE: begin
        pos = model_find(beat.tag);
        if (pos >= QDEPTH) begin
          sts = STS_MISS;
        end else begin
          kept_seq = model_seq[pos];
          model_drop(pos);
          void'(model_put(beat.tag, kept_seq, beat.prio));
        end
      end
      CMD_CLEAR: model_count = 0;
      default: ;
    endcase
    r = '0;
    if (model_count > 0) begin
      r.head_valid = 1'b1;
      r.head_tag   = model_tag[0];
      r.head_seq   = model_seq[0];
      r.head_prio  = model_prio[0];
    end
    r.fill_count = FILL_W'(model_count);
    r.status     = sts;
    return r;
  endfunction

  // ---------------------------------------------------------------- monitors

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) expected_heads.push_back(predict_head(in_data));
  end

  task automatic report_mismatch(input string what, input logic [FIELD_W-1:0] got,
                                 input logic [FIELD_W-1:0] want);
    // keep the log readable when something breaks badly
    if (err_count < 100)
      $display("[%0t] mismatch %s: got %0h want %0h", $realtime, what, got, want);
    err_count++;
  endtask

  always @(posedge clk) begin : check_results
    spq_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_heads.size() == 0) begin
        report_mismatch("unexpected beat, head_tag", out_data.head_tag, '0);
      end else begin
        want = expected_heads.pop_front();
        if (out_data.head_valid !== want.head_valid)
          report_mismatch("head_valid", FIELD_W'(out_data.head_valid),
                          FIELD_W'(want.head_valid));
        if (out_data.head_tag !== want.head_tag)
          report_mismatch("head_tag", out_data.head_tag, want.head_tag);
        if (out_data.head_seq !== want.head_seq)
          report_mismatch("head_seq", out_data.head_seq, want.head_seq);
        if (out_data.head_prio !== want.head_prio)
          report_mismatch("head_prio", out_data.head_prio, want.head_prio);
        if (out_data.fill_count !== want.fill_count)
          report_mismatch("fill_count", FIELD_W'(out_data.fill_count),
                          FIELD_W'(want.fill_count));
        if (out_data.status !== want.status)
          report_mismatch("status", FIELD_W'(out_data.status), FIELD_W'(want.status));
      end
    end
  end

  // result side: long hold-off when requested, random stalls otherwise
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // ---------------------------------------------------------------- stimulus helpers

  function automatic spq_in_t make_cmd_beat(logic [CMD_W-1:0] c, logic [FIELD_W-1:0] t,
                                            logic [FIELD_W-1:0] s, logic [FIELD_W-1:0] p);
    spq_in_t b;
    b.cmd     = c;
    b.tag     = t;
    b.seq_num = s;
    b.prio    = p;
    return b;
  endfunction

  function automatic spq_in_t make_random_beat(int ins_pct);
    spq_in_t b;
    int roll;
    roll = $urandom_range(99);
    if (roll < ins_pct) begin
      b.cmd = CMD_INSERT;
    end else begin
      roll = $urandom_range(99);
      if (roll < 30)      b.cmd = CMD_EXTRACT;
      else if (roll < 60) b.cmd = CMD_REMOVE;
      else if (roll < 90) b.cmd = CMD_CHANGE;
      else if (roll < 95) b.cmd = CMD_CLEAR;
      else                b.cmd = CMD_W'($urandom_range(CMD_UNUSED_HI, CMD_UNUSED_LO));
    end
    // mostly reuse a few tags so remove and change usually hit
    if ($urandom_range(99) < 80) b.tag = tag_pool[3'($urandom_range(7))];
    else                         b.tag = FIELD_W'($urandom);
    b.seq_num = FIELD_W'($urandom);
    // narrow priorities make plenty of ties
    if ($urandom_range(99) < 50) b.prio = FIELD_W'($urandom_range(3));
    else                         b.prio = FIELD_W'($urandom);
    return b;
  endfunction

  task automatic send_beat(input spq_in_t beat);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_heads.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_empty_queue_ops();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_beat(make_cmd_beat(CMD_EXTRACT, 16'h0000, 16'h0000, 16'h0000));
    send_beat(make_cmd_beat(CMD_REMOVE,  16'hFFFF, 16'h0000, 16'h0000));
    send_beat(make_cmd_beat(CMD_CHANGE,  16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_beat(make_cmd_beat(CMD_CLEAR,   16'h0000, 16'h0000, 16'h0000));
    send_beat(make_cmd_beat(CMD_UNUSED_LO, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_beat(make_cmd_beat(CMD_UNUSED_HI, 16'h0000, 16'h0000, 16'h0000));
    wait_drain();
  endtask

  task automatic test_ordering();
    send_beat(make_cmd_beat(CMD_INSERT,  16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_beat(make_cmd_beat(CMD_INSERT,  16'h0000, 16'h0000, 16'h0000));
    // equal priority goes behind the older entry
    send_beat(make_cmd_beat(CMD_INSERT,  16'h1234, 16'h0001, 16'hFFFF));
    // seq field is ignored, the stored one is kept
    send_beat(make_cmd_beat(CMD_CHANGE,  16'hFFFF, 16'h5555, 16'h0000));
    send_beat(make_cmd_beat(CMD_EXTRACT, 16'h0000, 16'h0000, 16'h0000));
    send_beat(make_cmd_beat(CMD_INSERT,  16'h1234, 16'h0002, 16'h8000));
    send_beat(make_cmd_beat(CMD_REMOVE,  16'h1234, 16'h0000, 16'h0000));
    send_beat(make_cmd_beat(CMD_REMOVE,  16'hABCD, 16'h0000, 16'h0000));
    send_beat(make_cmd_beat(CMD_CHANGE,  16'hABCD, 16'h0000, 16'h0001));
    send_beat(make_cmd_beat(CMD_CLEAR,   16'h0000, 16'h0000, 16'h0000));
    wait_drain();
  endtask

  task automatic test_full_queue();
    int i;
    for (i = 0; i < QDEPTH; i++)
      send_beat(make_cmd_beat(CMD_INSERT, FIELD_W'(16'h0100 + i), FIELD_W'(i),
                              FIELD_W'(i % 3)));
    send_beat(make_cmd_beat(CMD_INSERT,  16'h0200, 16'h0000, 16'h0000));
    send_beat(make_cmd_beat(CMD_CHANGE,  16'h0100, 16'h0000, 16'hFFFF));
    send_beat(make_cmd_beat(CMD_REMOVE,  16'h0105, 16'h0000, 16'h0000));
    send_beat(make_cmd_beat(CMD_EXTRACT, 16'h0000, 16'h0000, 16'h0000));
    send_beat(make_cmd_beat(CMD_CLEAR,   16'h0000, 16'h0000, 16'h0000));
    wait_drain();
  endtask

  task automatic test_random_traffic(input int n, input int idle_pct, input int stall_pct,
                                     input int ins_pct);
    int i;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    foreach (tag_pool[i]) tag_pool[i] = FIELD_W'($urandom);
    for (i = 0; i < n; i++) send_beat(make_random_beat(ins_pct));
    wait_drain();
  endtask

  task automatic test_backpressure();
    int i;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    foreach (tag_pool[i]) tag_pool[i] = FIELD_W'($urandom);
    // sender keeps offering while results are held back
    hold_left = 300;
    for (i = 0; i < 30; i++) send_beat(make_random_beat(60));
    wait_drain();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_queue_ops();
    test_ordering();
    test_full_queue();
    test_random_traffic(240, 0, 0, 60);
    test_random_traffic(240, 54, 0, 55);
    test_random_traffic(240, 0, 54, 65);
    test_random_traffic(240, 30, 30, 50);
    test_backpressure();
    repeat (10) @(posedge clk);
    if (err_count == 0 && expected_heads.size() == 0)
      $display("tb_top OK");
    else
      $display("tb_top NOT OK");
    $finish;
  end

endmodule
